### hdl/wwts_pkg.sv
// ----------------------------------------------------------------------------
// Weekly window trigger scan: shared package
// Field widths, stream packing offsets, table entry layout and the
// request/response bundles of the serial remainder unit.
// ----------------------------------------------------------------------------
package wwts_pkg;

  // Time of day in seconds, and the same value grown by one carry bit.
  localparam int TIME_W = 17;
  localparam int WIDE_W = TIME_W + 1;
  localparam int MASK_W = 7;
  localparam int IDX_IN_W = 4;
  localparam int WDAY_W = 3;
  localparam int COUNT_W = 5;
  localparam int FLAGS_OUT_W = 16;

  // Item kinds carried on tuser.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // Input tdata layout, lowest bit first.
  localparam int IN_IDX_LO    = 0;
  localparam int IN_BEGIN_LO  = IN_IDX_LO + IDX_IN_W;
  localparam int IN_PERIOD_LO = IN_BEGIN_LO + TIME_W;
  localparam int IN_ACTIVE_LO = IN_PERIOD_LO + TIME_W;
  localparam int IN_MASK_LO   = IN_ACTIVE_LO + TIME_W;
  localparam int IN_INV_LO    = IN_MASK_LO + MASK_W;
  localparam int IN_NOW_LO    = IN_INV_LO + 1;
  localparam int IN_WDAY_LO   = IN_NOW_LO + TIME_W;
  localparam int IN_USED_W    = IN_WDAY_LO + WDAY_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int OUT_MASK_LO  = 0;
  localparam int OUT_NEXT_LO  = OUT_MASK_LO + FLAGS_OUT_W;
  localparam int OUT_USED_W   = OUT_NEXT_LO + TIME_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // One trigger table entry.
  typedef struct packed {
    logic [TIME_W-1:0] begin_time;
    logic [TIME_W-1:0] period_length;
    logic [TIME_W-1:0] active_length;
    logic [MASK_W-1:0] week_mask;
    logic              invert;
  } entry_t;

  // Remainder unit request and response.
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] rem;
  } div_rsp_t;

endpackage

### hdl/wwts_divider.sv
// ----------------------------------------------------------------------------
// Weekly window trigger scan: serial remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module wwts_divider (
  input  logic              clk,
  input  logic              rst,
  input  wwts_pkg::div_req_t req,
  output wwts_pkg::div_rsp_t rsp
);

  localparam int STEP_W = $clog2(wwts_pkg::TIME_W + 1);

  logic [wwts_pkg::TIME_W-1:0] quo;
  logic [wwts_pkg::TIME_W-1:0] divisor;
  logic [wwts_pkg::TIME_W-1:0] rem;
  logic [STEP_W-1:0]           steps;
  logic                        busy;
  logic                        done;

  logic [wwts_pkg::WIDE_W-1:0] trial;
  logic [wwts_pkg::WIDE_W-1:0] trial_diff;
  logic                        trial_fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial      = {rem, quo[wwts_pkg::TIME_W-1]};
    trial_diff = trial - {1'b0, divisor};
    trial_fits = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
        steps   <= STEP_W'(wwts_pkg::TIME_W);
        busy    <= 1'b1;
      end else if (busy) begin
        quo   <= {quo[wwts_pkg::TIME_W-2:0], 1'b0};
        rem   <= trial_fits ? trial_diff[wwts_pkg::TIME_W-1:0]
                            : trial[wwts_pkg::TIME_W-1:0];
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

### hdl/wwts_table.sv
// ----------------------------------------------------------------------------
// Weekly window trigger scan: trigger table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wwts_table #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  wwts_pkg::entry_t     wdata,
  input  logic [IDX_W-1:0]     raddr,
  output wwts_pkg::entry_t     rdata
);

  wwts_pkg::entry_t mem [ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/weekly_window_trigger_scan_core.sv
// ----------------------------------------------------------------------------
// Weekly window trigger scan core
// Holds a table of time-of-day triggers and scans it on an evaluate item,
// updating the flags of matching entries (not repeating ones yet to begin) and finding the next window edge.
// ----------------------------------------------------------------------------
// Sequence: a write item, or an evaluate item with no entry in use, goes straight to the done
// state; each scanned entry passes through the read and check states (skipped, once-daily or
// not begun), or also through the serial remainder, start and finish states (repeating).
// Throughput: one item at a time, next accepted in the cycle after its result is registered,
// even while that result waits on the output.
// Reset (rst, synchronous) clears flags, entry count and handshakes; table is undefined.
module weekly_window_trigger_scan_core #(
  parameter int ENTRIES         = 16,
  parameter int SECONDS_PER_DAY = 86400
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_index, begin_time, period_length, active_length, week_mask,
  // invert, now_seconds, weekday (lowest bit first), zero padded
  input  logic [wwts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // active_mask, next_event (lowest bit first), zero padded
  output logic [wwts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [wwts_pkg::COUNT_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [8:0] ENTRIES9 = 9'(ENTRIES);
  localparam logic [wwts_pkg::WIDE_W-1:0] DAY = wwts_pkg::WIDE_W'(SECONDS_PER_DAY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_START,
    ST_FINISH,
    ST_DONE
  } state_t;

  state_t state;

  // Input fields.
  logic [wwts_pkg::IDX_IN_W-1:0] in_index;
  wwts_pkg::entry_t              in_entry;
  logic [wwts_pkg::TIME_W-1:0]   in_now;
  logic [wwts_pkg::WDAY_W-1:0]   in_wday;

  assign in_index               = s_axis_tdata[wwts_pkg::IN_IDX_LO +: wwts_pkg::IDX_IN_W];
  assign in_entry.begin_time    = s_axis_tdata[wwts_pkg::IN_BEGIN_LO +: wwts_pkg::TIME_W];
  assign in_entry.period_length = s_axis_tdata[wwts_pkg::IN_PERIOD_LO +: wwts_pkg::TIME_W];
  assign in_entry.active_length = s_axis_tdata[wwts_pkg::IN_ACTIVE_LO +: wwts_pkg::TIME_W];
  assign in_entry.week_mask     = s_axis_tdata[wwts_pkg::IN_MASK_LO +: wwts_pkg::MASK_W];
  assign in_entry.invert        = s_axis_tdata[wwts_pkg::IN_INV_LO];
  assign in_now                 = s_axis_tdata[wwts_pkg::IN_NOW_LO +: wwts_pkg::TIME_W];
  assign in_wday                = s_axis_tdata[wwts_pkg::IN_WDAY_LO +: wwts_pkg::WDAY_W];

  // Working registers.
  logic [wwts_pkg::COUNT_W-1:0]  entry_count;
  logic [ENTRIES-1:0]            flags;
  logic [wwts_pkg::TIME_W-1:0]   now;
  logic [wwts_pkg::WDAY_W-1:0]   wday;
  logic [CNT_W-1:0]              scan_idx;
  logic [CNT_W-1:0]              scan_count;
  logic [wwts_pkg::WIDE_W-1:0]   best;
  logic [wwts_pkg::TIME_W-1:0]   win_start;
  logic [wwts_pkg::WIDE_W-1:0]   win_end;
  logic [wwts_pkg::WIDE_W-1:0]   next_start;
  logic                          div_start;
  logic [wwts_pkg::TIME_W-1:0]   div_dividend;
  logic [wwts_pkg::TIME_W-1:0]   div_divisor;
  logic                          out_valid;
  logic [wwts_pkg::FLAGS_OUT_W-1:0] out_mask;
  logic [wwts_pkg::TIME_W-1:0]   out_next;

  // Table write address and range check.
  logic [8:0]       wr_idx9;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             accept;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign wr_idx9 = 9'(in_index);
  assign wr_addr = wr_idx9[IDX_W-1:0];
  assign wr_en   = accept && (s_axis_tuser == wwts_pkg::KIND_WRITE) && (wr_idx9 < ENTRIES9);

  wwts_pkg::entry_t ent;

  wwts_table #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_entry),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (ent)
  );

  // Shared remainder unit.
  wwts_pkg::div_req_t div_req;
  wwts_pkg::div_rsp_t div_rsp;

  assign div_req.start    = div_start;
  assign div_req.dividend = div_dividend;
  assign div_req.divisor  = div_divisor;

  wwts_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Scan count, saturated to the table size.
  logic [8:0]       count9;
  logic [CNT_W-1:0] count_sat;

  assign count9    = 9'(entry_count);
  assign count_sat = (count9 > ENTRIES9) ? ENTRIES9[CNT_W-1:0] : count9[CNT_W-1:0];

  // Per-entry decisions for the current table word.
  logic [wwts_pkg::MASK_W-1:0]  wday_bit;
  logic                         day_match;
  logic [wwts_pkg::WIDE_W-1:0]  once_end;
  logic                         once_open;
  logic                         once_has;
  logic [wwts_pkg::WIDE_W-1:0]  once_cand;
  logic [wwts_pkg::WIDE_W-1:0]  begin_w;
  logic                         before_begin;
  logic                         rep_open;
  logic [wwts_pkg::WIDE_W-1:0]  rep_cand;
  logic [CNT_W-1:0]             scan_idx_inc;
  logic                         scan_last;

  always_comb begin
    wday_bit     = wwts_pkg::MASK_W'(8'b1 << wday);
    day_match    = |(ent.week_mask & wday_bit);
    begin_w      = {1'b0, ent.begin_time};
    once_end     = begin_w + {1'b0, ent.active_length};
    once_open    = (ent.begin_time <= now) && ({1'b0, now} < once_end);
    before_begin = now < ent.begin_time;
    once_has     = once_open || before_begin;
    once_cand    = once_open ? once_end : begin_w;
    rep_open     = {1'b0, now} < win_end;
    rep_cand     = rep_open ? win_end : next_start;
    scan_idx_inc = scan_idx + 1'b1;
    scan_last    = scan_idx_inc == scan_count;
  end

  // Shown flags: only the first sixteen entries reach the output.
  logic [wwts_pkg::FLAGS_OUT_W-1:0] shown_flags;

  for (genvar g = 0; g < wwts_pkg::FLAGS_OUT_W; g++) begin : g_shown
    if (g < ENTRIES) begin : g_have
      assign shown_flags[g] = flags[g];
    end else begin : g_none
      assign shown_flags[g] = 1'b0;
    end
  end

  // Sequencer, working registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      flags       <= '0;
      entry_count <= '0;
      div_start   <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_count <= cfg_wdata;
      end
      // The result register loads in the done state when free and clears once taken.
      if (state == ST_DONE && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            now        <= in_now;
            wday       <= in_wday;
            scan_idx   <= '0;
            scan_count <= count_sat;
            best       <= DAY;
            if (s_axis_tuser == wwts_pkg::KIND_WRITE || count_sat == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_READ;
            end
          end
        end

        ST_READ: begin
          state <= ST_CHECK;
        end

        ST_CHECK: begin
          if (day_match && ent.period_length != '0 && !before_begin) begin
            // Repeating window already started: find the phase in the period.
            div_dividend <= now - ent.begin_time;
            div_divisor  <= ent.period_length;
            div_start    <= 1'b1;
            state        <= ST_DIV;
          end else begin
            if (day_match && ent.period_length == '0) begin
              flags[scan_idx[IDX_W-1:0]] <= ent.invert ^ once_open;
              if (once_has && once_cand < best) begin
                best <= once_cand;
              end
            end else if (day_match && begin_w < best) begin
              // Repeating window not yet begun: flag kept, begin is the edge.
              best <= begin_w;
            end
            scan_idx <= scan_idx_inc;
            state    <= scan_last ? ST_DONE : ST_READ;
          end
        end

        ST_DIV: begin
          div_start <= 1'b0;
          if (div_rsp.done) begin
            win_start <= now - div_rsp.rem;
            state     <= ST_START;
          end
        end

        ST_START: begin
          win_end    <= {1'b0, win_start} + {1'b0, ent.active_length};
          next_start <= {1'b0, win_start} + {1'b0, ent.period_length};
          state      <= ST_FINISH;
        end

        ST_FINISH: begin
          flags[scan_idx[IDX_W-1:0]] <= ent.invert ^ rep_open;
          if (rep_cand < best) begin
            best <= rep_cand;
          end
          scan_idx <= scan_idx_inc;
          state    <= scan_last ? ST_DONE : ST_READ;
        end

        ST_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_mask  <= shown_flags;
            out_next  <= (best >= DAY) ? '0 : best[wwts_pkg::TIME_W-1:0];
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = wwts_pkg::OUT_DATA_W'({out_next, out_mask});

endmodule

### hdl/wwts_checker.sv
// ----------------------------------------------------------------------------
// Weekly window trigger scan: port checker
// Watches the top-level ports for reset, busy, stall and result-range behavior.
// ----------------------------------------------------------------------------
module wwts_checker #(
  parameter int SECONDS_PER_DAY = 86400
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [wwts_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // No result is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready in the cycle after an accepted item");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // The next event always lies within the day.
  a_next_in_day: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[wwts_pkg::OUT_NEXT_LO +: wwts_pkg::TIME_W] < SECONDS_PER_DAY))
    else $error("next event beyond the end of the day");

endmodule

bind weekly_window_trigger_scan_core wwts_checker #(
  .SECONDS_PER_DAY (SECONDS_PER_DAY)
) u_wwts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
